// ----- hdl/oer_pkg.sv -----
package oer_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ByteW  = 8;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [ByteW-1:0] arg;
    logic [ByteW-1:0] kind;
    logic [TimeW-1:0] stamp;
  } entry_t;

endpackage

// ----- hdl/overwriting_event_ring.sv -----
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o      | mode_i, event_kind_i, event_arg_i, time_us_i
// output   | out_valid_o / out_stall_i    | got_event_o, out_time_o, out_kind_o,
//          |                              | out_arg_o, out_seq_o
//
// One transaction is accepted per cycle while the output register is free or being drained.
// A pop result appears in the output register in the cycle after the pop is accepted; the
// ring read port is the only stage between the counters and that register.
// A push produces no output transaction and completes at its accept edge.
// Reset clears both counters and the output valid; ring contents are not cleared.
// A stalled output result holds the input side stalled until it is taken.
module overwriting_event_ring
  import oer_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [ByteW-1:0]  event_kind_i,
  input  logic [ByteW-1:0]  event_arg_i,
  input  logic [TimeW-1:0]  time_us_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              got_event_o,
  output logic [TimeW-1:0]  out_time_o,
  output logic [ByteW-1:0]  out_kind_o,
  output logic [ByteW-1:0]  out_arg_o,
  output logic [SeqW-1:0]   out_seq_o
);

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [CountW-1:0] DepthC = CountW'(RING_DEPTH);

  entry_t            mem_q [RING_DEPTH];
  entry_t            rdata_q;
  entry_t            wentry;
  logic [CountW-1:0] wr_q, wr_d;
  logic [CountW-1:0] rd_q, rd_d;
  logic [CountW-1:0] fill;
  logic [CountW-1:0] rd_pos;
  logic              out_valid_q, out_valid_d;
  logic              got_q, got_d;
  logic              accept, acc_push, acc_pop, empty;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_push   = accept && (mode_e'(mode_i) == MODE_PUSH);
  assign acc_pop    = accept && (mode_e'(mode_i) == MODE_POP);

  assign empty  = (rd_q == wr_q);
  assign fill   = wr_q - rd_q;
  assign rd_pos = (fill > DepthC) ? (wr_q - DepthC) : rd_q;

  assign wentry = '{seq: wr_q[SeqW-1:0], arg: event_arg_i, kind: event_kind_i,
                    stamp: time_us_i};

  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    got_d       = got_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (acc_push) begin
      wr_d = wr_q + 1'b1;
    end
    if (acc_pop) begin
      out_valid_d = 1'b1;
      got_d       = !empty;
      if (!empty) begin
        rd_d = rd_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
      got_q       <= 1'b0;
    end else begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      got_q       <= got_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_push) begin
      mem_q[wr_q[IdxW-1:0]] <= wentry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_pop) begin
      rdata_q <= mem_q[rd_pos[IdxW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign got_event_o = got_q;
  assign out_time_o  = got_q ? rdata_q.stamp : '0;
  assign out_kind_o  = got_q ? rdata_q.kind  : '0;
  assign out_arg_o   = got_q ? rdata_q.arg   : '0;
  assign out_seq_o   = got_q ? rdata_q.seq   : '0;

  a_pop_bounds_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pop && !empty |=> (wr_q - rd_q) < DepthC)
    else $error("Read counter left more than the ring depth behind after a pop.");

  a_empty_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pop && empty |=> out_valid_o && !got_event_o && (out_time_o == '0))
    else $error("Empty pop did not return an empty result.");

  a_push_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_push |=> (wr_q == $past(wr_q) + 1'b1) && (rd_q == $past(rd_q)))
    else $error("Push did not advance only the write counter.");

  a_pop_keeps_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pop |=> wr_q == $past(wr_q))
    else $error("Pop changed the write counter.");

endmodule

// ----- tb/event_ring_sb_pkg.sv -----
package event_ring_sb_pkg;
  import oer_pkg::*;

  localparam int unsigned RingSlots = 64;

  typedef struct packed {
    logic   got;
    entry_t ev;
  } pop_result_t;

  class ring_scoreboard;
    entry_t            slots [RingSlots];
    logic [CountW-1:0] wr_count;
    logic [CountW-1:0] rd_count;
    pop_result_t       pending_pops [$];
    int unsigned       errors;

    function new();
      wr_count = '0;
      rd_count = '0;
      errors   = 0;
    endfunction

    function void note_input(mode_e mode, logic [ByteW-1:0] kind, logic [ByteW-1:0] arg,
                             logic [TimeW-1:0] stamp);
      pop_result_t       res;
      logic [CountW-1:0] rd;
      if (mode == MODE_PUSH) begin
        slots[int'(wr_count % RingSlots)] = '{seq: wr_count[SeqW-1:0], arg: arg, kind: kind,
                                              stamp: stamp};
        wr_count = wr_count + 1'b1;
        return;
      end
      res = '0;
      rd  = rd_count;
      if (rd != wr_count) begin
        // The writer has lapped the reader, so skip ahead to the oldest entry still held.
        if (CountW'(wr_count - rd) > CountW'(RingSlots)) begin
          rd = wr_count - CountW'(RingSlots);
        end
        res.got  = 1'b1;
        res.ev   = slots[int'(rd % RingSlots)];
        rd_count = rd + 1'b1;
      end
      pending_pops.push_back(res);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] have);
      if (have !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, have);
        errors++;
      end
    endfunction

    function void check_result(logic got, logic [TimeW-1:0] stamp, logic [ByteW-1:0] kind,
                               logic [ByteW-1:0] arg, logic [SeqW-1:0] seq);
      pop_result_t want;
      if (pending_pops.size() == 0) begin
        $display("%0t: result transaction with no pop waiting, expected none actual %b",
                 $time, got);
        errors++;
        return;
      end
      want = pending_pops.pop_front();
      compare("got_event", 32'(want.got), 32'(got));
      compare("out_time", want.ev.stamp, stamp);
      compare("out_kind", 32'(want.ev.kind), 32'(kind));
      compare("out_arg", 32'(want.ev.arg), 32'(arg));
      compare("out_seq", 32'(want.ev.seq), 32'(seq));
    endfunction

    function int unsigned pending();
      return pending_pops.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oer_pkg::*;
  import event_ring_sb_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             mode_i;
  logic [ByteW-1:0] event_kind_i;
  logic [ByteW-1:0] event_arg_i;
  logic [TimeW-1:0] time_us_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             got_event_o;
  logic [TimeW-1:0] out_time_o;
  logic [ByteW-1:0] out_kind_o;
  logic [ByteW-1:0] out_arg_o;
  logic [SeqW-1:0]  out_seq_o;

  ring_scoreboard sb;
  int unsigned    sender_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    quiet_cycles = 0;

  overwriting_event_ring #(
    .RING_DEPTH(RingSlots)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .event_kind_i(event_kind_i),
    .event_arg_i (event_arg_i),
    .time_us_i   (time_us_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .got_event_o (got_event_o),
    .out_time_o  (out_time_o),
    .out_kind_o  (out_kind_o),
    .out_arg_o   (out_arg_o),
    .out_seq_o   (out_seq_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(got_event_o, out_time_o, out_kind_o, out_arg_o, out_seq_o);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_txn(mode_e mode, logic [ByteW-1:0] kind, logic [ByteW-1:0] arg,
                          logic [TimeW-1:0] stamp);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    event_kind_i <= kind;
    event_arg_i  <= arg;
    time_us_i    <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(mode, kind, arg, stamp);
  endtask

  task automatic send_random(mode_e mode);
    send_txn(mode, ByteW'($urandom), ByteW'($urandom), $urandom);
  endtask

  task automatic run_random_traffic(int unsigned count);
    int unsigned left;
    int unsigned len;
    int unsigned pick;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = $urandom_range(60, 90);
      end else if (pick < 50) begin
        len = $urandom_range(1, 16);
      end else if (pick < 92) begin
        len = $urandom_range(1, 40);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int unsigned i = 0; i < len && left > 0; i++) begin
        if (pick < 50) begin
          send_random(MODE_PUSH);
        end else if (pick < 92) begin
          send_random(MODE_POP);
        end else begin
          send_random(mode_e'($urandom_range(0, 1)));
        end
        left--;
      end
    end
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_PUSH;
    event_kind_i = '0;
    event_arg_i  = '0;
    time_us_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An empty pop must ignore the push fields, so they are set to all ones here.
    send_txn(MODE_POP, 8'hff, 8'hff, 32'hffff_ffff);
    send_txn(MODE_PUSH, 8'h00, 8'h00, 32'h0000_0000);
    send_txn(MODE_PUSH, 8'hff, 8'hff, 32'hffff_ffff);
    send_txn(MODE_PUSH, 8'h5a, 8'ha5, 32'h8000_0001);
    send_txn(MODE_POP, 8'h00, 8'h00, 32'h0000_0000);
    send_txn(MODE_POP, 8'h12, 8'h34, 32'h5678_9abc);
    send_txn(MODE_POP, 8'hff, 8'h00, 32'hffff_0000);
    send_txn(MODE_POP, 8'h00, 8'hff, 32'h0000_ffff);
    send_txn(MODE_PUSH, 8'h01, 8'h80, 32'h7fff_ffff);
    send_txn(MODE_POP, 8'h00, 8'h00, 32'h0000_0000);
    send_txn(MODE_PUSH, 8'h80, 8'h01, 32'h0000_0001);
    send_txn(MODE_PUSH, 8'h7f, 8'hfe, 32'hfffe_ffff);
    send_txn(MODE_POP, 8'h00, 8'h00, 32'h0000_0000);
    send_txn(MODE_POP, 8'h00, 8'h00, 32'h0000_0000);
    send_txn(MODE_POP, 8'haa, 8'h55, 32'haaaa_5555);
    send_txn(MODE_POP, 8'h00, 8'h00, 32'h0000_0000);

    run_random_traffic(370);
    sender_idle_pct = 56;
    stall_pct       = 0;
    run_random_traffic(370);
    sender_idle_pct = 0;
    stall_pct       = 56;
    run_random_traffic(370);
    sender_idle_pct = 37;
    stall_pct       = 37;
    run_random_traffic(370);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
